### rtl/core/f2i16q_pkg.sv
// Shared constants and pipeline types for the float-to-int16 quantizer.
package f2i16q_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'd1;

  localparam logic [31:0] SCALE_RESET  = 32'h3F80_0000;
  localparam logic [31:0] OFFSET_RESET = 32'h0000_0000;

  localparam logic [31:0] F_INF = 32'h7F80_0000;
  localparam logic [31:0] F_NAN = 32'h7FC0_0000;

  localparam logic signed [15:0] QCODE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] QCODE_MIN = 16'sh8000;

  // exact operand ready for rounding: sign * mag * 2^exp, or a fixed special
  typedef struct packed {
    logic               sign;
    logic [63:0]        mag;
    logic signed [11:0] exp;
    logic               spec;
    logic [31:0]        spec_bits;
    logic               last;
  } rp_in_t;

  // rounding plan: shift amount and exponent field
  typedef struct packed {
    logic               sign;
    logic [63:0]        mag;
    logic signed [11:0] sh;
    logic [7:0]         biased;
    logic               ovf;
    logic               spec;
    logic [31:0]        spec_bits;
    logic               last;
  } rp_plan_t;

  typedef struct packed {
    logic [31:0] bits;
    logic        last;
  } fl_t;

  // aligned addends
  typedef struct packed {
    logic [62:0]        a_mag;
    logic [62:0]        b_mag;
    logic               sa;
    logic               sb;
    logic signed [11:0] exp;
    logic               spec;
    logic [31:0]        spec_bits;
    logic               last;
  } ad_t;

endpackage

### rtl/core/float_to_int16_quantizer_top.sv
// Float-to-int16 quantizer: pipelined scale multiply, offset add and int16 conversion.
//
// Takes one single-precision sample per clock (start high while busy is low;
// busy never rises, so every start is a transfer) and delivers its int16 code
// on out_code_value, flagged by a one-cycle out_valid strobe with out_last_out
// alongside. Throughput is one sample per cycle. The pipe has eight register
// stages: 24x24 mantissa multiply, leading-one search, round/pack of the
// product, operand alignment for the offset add, magnitude add/subtract,
// leading-one search, round/pack of the sum, and the round-half-away int16
// conversion. Both float operations round to nearest-even separately (no fused
// multiply-add) and handle subnormals. A NaN anywhere gives 32767, infinities
// saturate by sign. The receiver has no way to stall the pipe, so results must
// be taken as they appear. The scale and offset registers are written through
// cfg_we/cfg_index/cfg_data and should only change while no sample is in flight.
module float_to_int16_quantizer_top
  import f2i16q_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [31:0]           in_sample_bits,
  input  logic                  in_last_in,
  output logic                  out_valid,
  output logic signed [15:0]    out_code_value,
  output logic                  out_last_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  // ---------------------------------------------------------------------------
  // float helpers
  // ---------------------------------------------------------------------------
  function automatic logic f_nan(input logic [31:0] x);
    return x[30:0] > F_INF[30:0];
  endfunction

  function automatic logic f_inf(input logic [31:0] x);
    return x[30:0] == F_INF[30:0];
  endfunction

  function automatic logic f_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] f_man(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
  endfunction

  function automatic logic signed [11:0] f_exp(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? -12'sd149 : ($signed({4'd0, x[30:23]}) - 12'sd150);
  endfunction

  function automatic logic [5:0] msb64(input logic [63:0] m);
    logic [5:0] idx;
    idx = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  // pick the shift that lands the leading one at bit 23, or the subnormal shift
  function automatic rp_plan_t rp_plan(input rp_in_t x);
    rp_plan_t           o;
    logic signed [11:0] p;
    logic signed [11:0] pe;
    logic signed [11:0] sh_n;
    logic signed [11:0] sub;
    p    = $signed({6'd0, msb64(x.mag)});
    pe   = p + x.exp;
    sh_n = p - 12'sd23;
    sub  = -12'sd149 - x.exp;
    o.sign      = x.sign;
    o.mag       = x.mag;
    o.spec      = x.spec;
    o.spec_bits = x.spec_bits;
    o.last      = x.last;
    if (sh_n >= sub) begin
      o.sh     = sh_n;
      o.ovf    = pe > 12'sd127;
      o.biased = 8'(pe + 12'sd126);
    end else begin
      o.sh     = sub;
      o.ovf    = 1'b0;
      o.biased = 8'd0;
    end
    return o;
  endfunction

  // shift, round to nearest-even and pack
  function automatic logic [31:0] rp_do(input rp_plan_t x);
    logic [63:0]        q;
    logic [127:0]       sx;
    logic [6:0]         shr;
    logic signed [11:0] nsh;
    logic [32:0]        sum;
    logic [31:0]        res;
    q   = 64'd0;
    sx  = 128'd0;
    shr = 7'd0;
    nsh = -x.sh;
    sum = 33'd0;
    if (x.spec) begin
      res = x.spec_bits;
    end else if (x.ovf) begin
      res = {x.sign, F_INF[30:0]};
    end else begin
      if (x.sh < 12'sd0) begin
        q = x.mag << nsh[4:0];
      end else begin
        shr = (x.sh > 12'sd65) ? 7'd65 : x.sh[6:0];
        sx  = {x.mag, 64'd0} >> shr;
        q   = sx[127:64];
        if (sx[63] && ((|sx[62:0]) || q[0])) q = q + 64'd1;
      end
      sum = {2'd0, x.biased, 23'd0} + {8'd0, q[24:0]};
      if (sum >= {1'b0, F_INF}) res = {x.sign, F_INF[30:0]};
      else res = {x.sign, sum[30:0]};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] scale_r, offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SCALE) scale_r <= cfg_data;
      if (cfg_index == CFG_OFFSET) offset_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline registers
  // ---------------------------------------------------------------------------
  logic [8:1]         v_r, v_nxt;
  rp_in_t             s1_r, s1_nxt;
  rp_plan_t           s2_r, s2_nxt;
  fl_t                s3_r, s3_nxt;
  ad_t                s4_r, s4_nxt;
  rp_in_t             s5_r, s5_nxt;
  rp_plan_t           s6_r, s6_nxt;
  fl_t                s7_r, s7_nxt;
  logic signed [15:0] code_r, code_nxt;
  logic               last_r, last_nxt;

  assign busy = 1'b0;

  // valid bits march with the data; no stall
  assign v_nxt = {v_r[7:1], start && !busy};

  // stage 1: mantissa product and special cases of the multiply
  always_comb begin
    logic [31:0] a, b;
    a = in_sample_bits;
    b = scale_r;
    s1_nxt.sign      = a[31] ^ b[31];
    s1_nxt.mag       = {16'd0, {24'd0, f_man(a)} * {24'd0, f_man(b)}};
    s1_nxt.exp       = f_exp(a) + f_exp(b);
    s1_nxt.last      = in_last_in;
    s1_nxt.spec      = 1'b1;
    s1_nxt.spec_bits = {s1_nxt.sign, 31'd0};
    if (f_nan(a) || f_nan(b)) begin
      s1_nxt.spec_bits = F_NAN;
    end else if (f_inf(a) || f_inf(b)) begin
      if (f_zero(a) || f_zero(b)) s1_nxt.spec_bits = F_NAN;
      else s1_nxt.spec_bits = {s1_nxt.sign, F_INF[30:0]};
    end else if (!(f_zero(a) || f_zero(b))) begin
      s1_nxt.spec = 1'b0;
    end
  end

  // stage 2 and 3: round the product
  assign s2_nxt      = rp_plan(s1_r);
  assign s3_nxt.bits = rp_do(s2_r);
  assign s3_nxt.last = s2_r.last;

  // stage 4: special cases of the add, operand swap and alignment
  always_comb begin
    logic [31:0]        a, b;
    logic [23:0]        ma, mb;
    logic signed [11:0] ea, eb, d, r;
    logic               sa, sb;
    logic [5:0]         k;
    a  = s3_r.bits;
    b  = offset_r;
    ma = f_man(a);
    mb = f_man(b);
    ea = f_exp(a);
    eb = f_exp(b);
    sa = a[31];
    sb = b[31];
    if (ea < eb) begin
      ma = f_man(b);
      mb = f_man(a);
      ea = f_exp(b);
      eb = f_exp(a);
      sa = b[31];
      sb = a[31];
    end
    d = ea - eb;
    k = (d > 12'sd38) ? 6'd38 : d[5:0];
    r = d - $signed({6'd0, k});
    s4_nxt.a_mag = {39'd0, ma} << k;
    if (r >= 12'sd24) begin
      s4_nxt.b_mag = 63'd1;
    end else begin
      s4_nxt.b_mag = {39'd0, mb >> r[4:0]};
      if (((mb >> r[4:0]) << r[4:0]) != mb) s4_nxt.b_mag[0] = 1'b1;
    end
    s4_nxt.sa   = sa;
    s4_nxt.sb   = sb;
    s4_nxt.exp  = ea - $signed({6'd0, k});
    s4_nxt.last = s3_r.last;
    s4_nxt.spec = 1'b1;
    if (f_nan(a) || f_nan(b)) begin
      s4_nxt.spec_bits = F_NAN;
    end else if (f_inf(a) && f_inf(b)) begin
      s4_nxt.spec_bits = (a[31] == b[31]) ? a : F_NAN;
    end else if (f_inf(a)) begin
      s4_nxt.spec_bits = a;
    end else if (f_inf(b)) begin
      s4_nxt.spec_bits = b;
    end else if (f_zero(a) && f_zero(b)) begin
      s4_nxt.spec_bits = {a[31] & b[31], 31'd0};
    end else if (f_zero(a)) begin
      s4_nxt.spec_bits = b;
    end else if (f_zero(b)) begin
      s4_nxt.spec_bits = a;
    end else begin
      s4_nxt.spec      = 1'b0;
      s4_nxt.spec_bits = 32'd0;
    end
  end

  // stage 5: magnitude add or subtract
  always_comb begin
    s5_nxt.exp       = s4_r.exp;
    s5_nxt.last      = s4_r.last;
    s5_nxt.spec      = s4_r.spec;
    s5_nxt.spec_bits = s4_r.spec_bits;
    s5_nxt.sign      = s4_r.sa;
    s5_nxt.mag       = {1'b0, s4_r.a_mag + s4_r.b_mag};
    if (s4_r.sa != s4_r.sb) begin
      if (s4_r.a_mag > s4_r.b_mag) begin
        s5_nxt.mag = {1'b0, s4_r.a_mag - s4_r.b_mag};
      end else if (s4_r.b_mag > s4_r.a_mag) begin
        s5_nxt.sign = s4_r.sb;
        s5_nxt.mag  = {1'b0, s4_r.b_mag - s4_r.a_mag};
      end else if (!s4_r.spec) begin
        // exact cancellation gives +0
        s5_nxt.spec      = 1'b1;
        s5_nxt.spec_bits = 32'd0;
      end
    end
  end

  // stage 6 and 7: round the sum
  assign s6_nxt      = rp_plan(s5_r);
  assign s7_nxt.bits = rp_do(s6_r);
  assign s7_nxt.last = s6_r.last;

  // stage 8: round half away from zero and saturate to int16
  always_comb begin
    logic [31:0]        x;
    logic [16:0]        q;
    logic signed [11:0] s;
    logic [24:0]        rs;
    x  = s7_r.bits;
    q  = 17'd0;
    s  = -f_exp(x);
    rs = 25'd0;
    if (x[30:23] >= 8'd142) begin
      q = 17'd32768;
    end else if (!f_zero(x) && (s < 12'sd25)) begin
      rs = ({1'b0, f_man(x)} + (25'd1 << (s[4:0] - 5'd1))) >> s[4:0];
      q  = rs[16:0];
    end
    if (f_nan(x)) code_nxt = QCODE_MAX;
    else if (!x[31]) code_nxt = (q > 17'd32767) ? QCODE_MAX : $signed(q[15:0]);
    else code_nxt = $signed(16'(17'h10000 - q));
    last_nxt = s7_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
    s1_r   <= s1_nxt;
    s2_r   <= s2_nxt;
    s3_r   <= s3_nxt;
    s4_r   <= s4_nxt;
    s5_r   <= s5_nxt;
    s6_r   <= s6_nxt;
    s7_r   <= s7_nxt;
    code_r <= code_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = v_r[8];
  assign out_code_value = code_r;
  assign out_last_out   = last_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_strobe_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 8))
    else $error("result strobe without a matching input transfer");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_out == $past(in_last_in, 8)))
    else $error("last flag does not follow its sample");

  a_nan_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_sample_bits[30:0] > F_INF[30:0], 8))
      |-> (out_code_value == QCODE_MAX))
    else $error("NaN sample did not give the missing-value code");

endmodule

### sim/f2i16q_checker.sv
// Checker for the float-to-int16 quantizer: predicts each code and compares results.
module f2i16q_checker
  import f2i16q_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [31:0]          in_sample_bits,
  input  logic                 in_last_in,
  input  logic                 out_valid,
  input  logic signed [15:0]   out_code_value,
  input  logic                 out_last_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   codes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] code;
    logic               last;
  } code_exp_t;

  logic [31:0] scale_q, offset_q;
  code_exp_t   code_fifo[$];

  function automatic bit is_nan(logic [31:0] x);
    return x[30:0] > F_INF[30:0];
  endfunction
  function automatic bit is_inf(logic [31:0] x);
    return x[30:0] == F_INF[30:0];
  endfunction
  function automatic bit is_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // finite x = m * 2^e
  function automatic void unpack_f(logic [31:0] x, output logic [63:0] m, output int e);
    if (x[30:23] == 8'd0) begin
      m = {41'd0, x[22:0]};
      e = -149;
    end else begin
      m = {40'd0, 1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end
  endfunction

  // round sign*m*2^e to single, ties to even
  function automatic logic [31:0] round_pack(logic sign, logic [63:0] m, int e);
    int p, sh, sub, biased;
    logic [63:0] q, rem, half, bits;
    p = 63;
    while (m[p] == 1'b0) p--;
    sh = p - 23;
    sub = -149 - e;
    if (sh >= sub) begin
      if (p + e > 127) return {sign, F_INF[30:0]};
      biased = p + e + 126;
    end else begin
      sh = sub;
      biased = 0;
    end
    if (sh <= 0) q = m << (-sh);
    else if (sh >= 64) q = (sh == 64 && m > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
    else begin
      rem = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      q = m >> sh;
      if (rem > half || (rem == half && q[0])) q++;
    end
    bits = (64'(biased) << 23) + q;
    if (bits >= 64'(F_INF)) bits = 64'(F_INF);
    return {sign, bits[30:0]};
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic s;
    logic [63:0] ma, mb;
    int ea, eb;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return F_NAN;
    if (is_inf(a) || is_inf(b)) begin
      if (is_zero(a) || is_zero(b)) return F_NAN;
      return {s, F_INF[30:0]};
    end
    if (is_zero(a) || is_zero(b)) return {s, 31'd0};
    unpack_f(a, ma, ea);
    unpack_f(b, mb, eb);
    return round_pack(s, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic sa, sb, st;
    logic [63:0] ma, mb, mt, wa, wb;
    int ea, eb, et, d, k, r;
    sa = a[31];
    sb = b[31];
    if (is_nan(a) || is_nan(b)) return F_NAN;
    if (is_inf(a) && is_inf(b)) return (sa == sb) ? a : F_NAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (is_zero(a) && is_zero(b)) return {sa & sb, 31'd0};
    if (is_zero(a)) return b;
    if (is_zero(b)) return a;
    unpack_f(a, ma, ea);
    unpack_f(b, mb, eb);
    if (ea < eb) begin
      mt = ma; ma = mb; mb = mt;
      et = ea; ea = eb; eb = et;
      st = sa; sa = sb; sb = st;
    end
    d = ea - eb;
    k = (d < 38) ? d : 38;
    r = d - k;
    wa = ma << k;
    // sticky bit for whatever falls off the bottom
    if (r >= 64) wb = 64'd1;
    else wb = (mb >> r) | 64'(((mb & ((64'd1 << r) - 64'd1)) != 64'd0));
    if (sa == sb) return round_pack(sa, wa + wb, ea - k);
    if (wa > wb) return round_pack(sa, wa - wb, ea - k);
    if (wb > wa) return round_pack(sb, wb - wa, ea - k);
    return 32'd0;
  endfunction

  // round half away from zero, saturate to int16
  function automatic logic signed [15:0] to_code(logic [31:0] x);
    logic [63:0] m, q;
    int e, s;
    logic [31:0] neg;
    if (is_nan(x)) return QCODE_MAX;
    if (x[30:23] >= 8'd142) q = 64'd32768;
    else if (is_zero(x)) q = 64'd0;
    else begin
      unpack_f(x, m, e);
      s = -e;
      if (s >= 25) q = 64'd0;
      else q = (m + (64'd1 << (s - 1))) >> s;
    end
    if (!x[31]) return (q > 64'd32767) ? QCODE_MAX : 16'(q);
    neg = 32'h10000 - 32'(q);
    return neg[15:0];
  endfunction

  function automatic logic signed [15:0] quantize(logic [31:0] smp);
    if (is_nan(smp)) return QCODE_MAX;
    return to_code(fadd(fmul(smp, scale_q), offset_q));
  endfunction

  always @(posedge clk) begin
    code_exp_t ce;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      scale_q <= SCALE_RESET;
      offset_q <= OFFSET_RESET;
      code_fifo.delete();
      fail_count <= 0;
      codes_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SCALE) scale_q <= cfg_data;
        else if (cfg_index == CFG_OFFSET) offset_q <= cfg_data;
      end
      if (out_valid) begin
        codes_seen <= codes_seen + 1;
        if (code_fifo.size() == 0) begin
          $error("result with no sample outstanding: code %0d", out_code_value);
          errs++;
        end else begin
          ce = code_fifo.pop_front();
          if (out_code_value !== ce.code) begin
            $error("code_value: expected %0d, got %0d", ce.code, out_code_value);
            errs++;
          end
          if (out_last_out !== ce.last) begin
            $error("last_out: expected %0b, got %0b", ce.last, out_last_out);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        ce.code = quantize(in_sample_bits);
        ce.last = in_last_in;
        code_fifo.push_back(ce);
      end
      fail_count <= fail_count + errs;
      pending <= code_fifo.size();
    end
  end

endmodule

### sim/tb_top.sv
// Testbench top for the float-to-int16 quantizer: stimulus, configuration and verdict.
module tb_top;
  import f2i16q_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT    = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_PHASES    = 7;
  localparam int PER_PHASE   = 92;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_sample_bits = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic signed [15:0] out_code_value;
  logic out_last_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCALE;
  logic [31:0] cfg_data = '0;
  int fail_count, pending, codes_seen;
  int cycle_cnt = 0;
  int sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  float_to_int16_quantizer_top dut (.*);

  f2i16q_checker chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sample mix: values near the int16 range, plus specials, exact halves and raw bits
  function automatic logic [31:0] rand_sample();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'hFF;                        // inf or NaN
      1: v[30:23] = 8'h00;                        // zero or subnormal
      2, 3, 4, 5: v[30:23] = 8'($urandom_range(120, 145));  // around rounding/saturation
      6: v[22:0] = {1'b1, 22'd0} >> $urandom_range(0, 22);  // exact halves
      default: ;
    endcase
    return v;
  endfunction

  // one transfer; a random idle burst ahead of it when allowed
  task automatic send(logic [31:0] smp, logic lst, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    start <= 1'b1;
    in_sample_bits <= smp;
    in_last_in <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // drain pipe before touching the registers
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (PIPE_LAT + 2) @(negedge clk);
  endtask

  logic [31:0] directed_smp[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001,
    32'h807F_FFFF, 32'h3F00_0000, 32'hBF00_0000, 32'h3FC0_0000,
    32'h46FF_FE00, 32'h46FF_FF00, 32'hC6FF_FF00, 32'hC700_0000,
    32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3EFF_FFFF, 32'h4040_0000
  };

  // scale/offset settings, including extremes, NaN, infinities and zero
  logic [31:0] phase_scale[N_PHASES] = '{
    32'h3F80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h7F80_0000,
    32'h0000_0000, 32'hFFFF_FFFF, 32'h3C23_D70A
  };
  logic [31:0] phase_offset[N_PHASES] = '{
    32'h0000_0000, 32'hFF80_0000, 32'h8000_0001, 32'hFF80_0000,
    32'h7FC0_0000, 32'h7F7F_FFFF, 32'hC2C8_0000
  };

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed samples under reset settings
    foreach (directed_smp[i]) send(directed_smp[i], i[0], 1'b0);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_SCALE, ph == 0 ? $urandom : phase_scale[ph]);
        write_reg(CFG_OFFSET, phase_offset[ph]);
      end else begin
        write_reg(CFG_OFFSET, phase_offset[ph]);
        write_reg(CFG_SCALE, phase_scale[ph]);
      end
      // late phases run back to back with no idling
      for (int n = 0; n < PER_PHASE; n++)
        send(rand_sample(), 1'($urandom), ph < N_PHASES - 2);
      drain();
    end
    // random register values too
    write_reg(CFG_SCALE, {2'b00, 30'($urandom)});
    write_reg(CFG_OFFSET, {1'($urandom), 8'($urandom_range(120, 145)), 23'($urandom)});
    repeat (30) send(rand_sample(), 1'($urandom), 1'b0);
    drain();

    $display("Ran %0d samples across %0d scale/offset settings; %0d codes compared.",
             sent, N_PHASES + 2, codes_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/f2i16q_pkg.sv
rtl/core/float_to_int16_quantizer_top.sv
sim/f2i16q_checker.sv
sim/tb_top.sv
